@@ design/ethp_pkg.sv @@
// ----------------------------------------------------------------------------
// ethp_pkg
// Shared types and constants for the Ethernet/IP/TCP header parser.
// ----------------------------------------------------------------------------
package ethp_pkg;

   localparam int MAX_FRAME_BYTES = 16384;
   localparam int IDX_W           = 15;

   localparam logic [15:0] KIND_VLAN = 16'h8100;
   localparam logic [15:0] KIND_IPV4 = 16'h0800;
   localparam logic [15:0] KIND_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   localparam logic [4:0] ETH_HDR_LEN  = 5'd14;
   localparam logic [4:0] VLAN_HDR_LEN = 5'd18;

   localparam logic [4:0] ST_TCP_OK     = 5'd0;
   localparam logic [4:0] ST_UDP        = 5'd1;
   localparam logic [4:0] ST_ETH_SHORT  = 5'd2;
   localparam logic [4:0] ST_BAD_KIND   = 5'd3;
   localparam logic [4:0] ST_RAW_VER    = 5'd4;
   localparam logic [4:0] ST_V4_SHORT   = 5'd5;
   localparam logic [4:0] ST_V4_VER     = 5'd6;
   localparam logic [4:0] ST_V4_IHL     = 5'd7;
   localparam logic [4:0] ST_V4_HDR_LEN = 5'd8;
   localparam logic [4:0] ST_V4_FRAG    = 5'd9;
   localparam logic [4:0] ST_V6_SHORT   = 5'd10;
   localparam logic [4:0] ST_V6_VER     = 5'd11;
   localparam logic [4:0] ST_BAD_PROTO  = 5'd12;
   localparam logic [4:0] ST_TCP_SHORT  = 5'd13;
   localparam logic [4:0] ST_TCP_OFFSET = 5'd14;
   localparam logic [4:0] ST_TOO_LONG   = 5'd16;

   // Per-frame capture state
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [15:0]      ek;
      logic [4:0]       ns;
      logic [3:0]       ipver;
      logic [3:0]       hw;
      logic [15:0]      iplen;
      logic [15:0]      frag;
      logic [7:0]       proto;
      logic [63:0]      src0;
      logic [63:0]      src1;
      logic [63:0]      dst0;
      logic [63:0]      dst1;
      logic [6:0]       ts;
      logic [15:0]      ofw;
      logic [15:0]      sport;
      logic [15:0]      dport;
      logic [31:0]      seq;
   } frame_type;

endpackage

@@ design/eth_ip_tcp_header_parser_top.sv @@
// ----------------------------------------------------------------------------
// eth_ip_tcp_header_parser_top
// Byte-stream header parser for Ethernet/802.1Q, IPv4/IPv6 and TCP.
// ----------------------------------------------------------------------------
//  channel | ports                        | direction | moves
//  req     | req_valid/ready, frame bytes | in        | one frame byte
//  rsp     | rsp_valid/ready, fields      | out       | one result per frame
//  csr     | csr_write_enable/data        | in        | raw_ip_mode bit
//
//  One byte is taken every cycle unless the input is stalled. A byte goes
//  through three registers: the input register, the capture state (frame
//  snapshot on the last byte) and the result register.
//  Reset clears the mode bit, the capture state and all valid flags.
//  A held result only stalls the input when a second last byte needs the
//  snapshot register; other bytes keep flowing.
// ----------------------------------------------------------------------------
module eth_ip_tcp_header_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_status,
   output logic        rsp_ip_is_v6,
   output logic [63:0] rsp_src_addr_hi,
   output logic [63:0] rsp_src_addr_lo,
   output logic [63:0] rsp_dst_addr_hi,
   output logic [63:0] rsp_dst_addr_lo,
   output logic [15:0] rsp_src_port,
   output logic [15:0] rsp_dst_port,
   output logic [31:0] rsp_seq_num,
   output logic [7:0]  rsp_tcp_flag_bits,
   output logic [14:0] rsp_payload_offset,
   output logic [14:0] rsp_payload_length,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam logic [ethp_pkg::IDX_W-1:0] MAX_IDX = ethp_pkg::IDX_W'(ethp_pkg::MAX_FRAME_BYTES);

   logic                mode_ff;
   logic                vld_ff;
   logic [7:0]          byte_ff;
   logic                last_ff;
   ethp_pkg::frame_type frm_ff, frm_in;
   logic                snap_vld_ff;
   ethp_pkg::frame_type snap_ff;
   logic                snap_mode_ff;
   logic                rsp_valid_ff;

   logic out_free, snap_free, cap_go;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign snap_free = !snap_vld_ff || out_free;
   assign cap_go    = vld_ff && (!last_ff || snap_free);
   assign req_ready = !vld_ff || cap_go;
   assign rsp_valid = rsp_valid_ff;

   // ---------------- capture ----------------
   logic [ethp_pkg::IDX_W-1:0] r_off, t_off;
   logic                       go_net, lay_v6;

   always_comb begin
      frm_in = frm_ff;
      go_net = 1'b0;
      lay_v6 = 1'b0;
      r_off  = '0;
      t_off  = '0;
      if (frm_ff.idx < MAX_IDX) begin
         if (!mode_ff) begin
            if (frm_ff.idx == 15'd12 || frm_ff.idx == 15'd13) begin
               frm_in.ek = {frm_in.ek[7:0], byte_ff};
            end
            if (frm_ff.idx == 15'd13) begin
               frm_in.ns = (frm_in.ek == ethp_pkg::KIND_VLAN) ?
                           ethp_pkg::VLAN_HDR_LEN : ethp_pkg::ETH_HDR_LEN;
            end
            if ((frm_ff.idx == 15'd16 || frm_ff.idx == 15'd17) &&
                frm_ff.ns == ethp_pkg::VLAN_HDR_LEN) begin
               frm_in.ek = {frm_in.ek[7:0], byte_ff};
            end
            go_net = (frm_ff.idx >= 15'd14) && (frm_ff.idx >= 15'(frm_in.ns));
         end else begin
            frm_in.ns = '0;
            go_net    = 1'b1;
         end
         r_off = frm_ff.idx - 15'(frm_in.ns);
         if (go_net) begin
            if (r_off == '0) begin
               frm_in.ipver = byte_ff[7:4];
               frm_in.hw    = byte_ff[3:0];
               lay_v6 = mode_ff ? (byte_ff[7:4] == 4'd6) : (frm_in.ek == ethp_pkg::KIND_IPV6);
               frm_in.ts = 7'(frm_in.ns) + (lay_v6 ? 7'd40 : 7'({byte_ff[3:0], 2'b00}));
            end else begin
               lay_v6 = mode_ff ? (frm_in.ipver == 4'd6) : (frm_in.ek == ethp_pkg::KIND_IPV6);
               if (lay_v6) begin
                  if (r_off == 15'd4 || r_off == 15'd5)
                     frm_in.iplen = {frm_in.iplen[7:0], byte_ff};
                  else if (r_off == 15'd6)
                     frm_in.proto = byte_ff;
                  else if (r_off >= 15'd8 && r_off < 15'd16)
                     frm_in.src0 = {frm_in.src0[55:0], byte_ff};
                  else if (r_off >= 15'd16 && r_off < 15'd24)
                     frm_in.src1 = {frm_in.src1[55:0], byte_ff};
                  else if (r_off >= 15'd24 && r_off < 15'd32)
                     frm_in.dst0 = {frm_in.dst0[55:0], byte_ff};
                  else if (r_off >= 15'd32 && r_off < 15'd40)
                     frm_in.dst1 = {frm_in.dst1[55:0], byte_ff};
               end else begin
                  if (r_off == 15'd2 || r_off == 15'd3)
                     frm_in.iplen = {frm_in.iplen[7:0], byte_ff};
                  else if (r_off == 15'd6 || r_off == 15'd7)
                     frm_in.frag = {frm_in.frag[7:0], byte_ff};
                  else if (r_off == 15'd9)
                     frm_in.proto = byte_ff;
                  else if (r_off >= 15'd12 && r_off < 15'd16)
                     frm_in.src1 = {frm_in.src1[55:0], byte_ff};
                  else if (r_off >= 15'd16 && r_off < 15'd20)
                     frm_in.dst1 = {frm_in.dst1[55:0], byte_ff};
               end
               if (frm_ff.idx >= 15'(frm_ff.ts)) begin
                  t_off = frm_ff.idx - 15'(frm_ff.ts);
                  if (t_off < 15'd2)
                     frm_in.sport = {frm_in.sport[7:0], byte_ff};
                  else if (t_off < 15'd4)
                     frm_in.dport = {frm_in.dport[7:0], byte_ff};
                  else if (t_off < 15'd8)
                     frm_in.seq = {frm_in.seq[23:0], byte_ff};
                  else if (t_off == 15'd12 || t_off == 15'd13)
                     frm_in.ofw = {frm_in.ofw[7:0], byte_ff};
               end
            end
         end
      end
      // saturate one past the limit
      if (frm_ff.idx <= MAX_IDX) begin
         frm_in.idx = frm_ff.idx + 15'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         vld_ff       <= 1'b0;
         frm_ff       <= '0;
         snap_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         if (req_valid && req_ready) begin
            vld_ff <= 1'b1;
         end else if (cap_go) begin
            vld_ff <= 1'b0;
         end
         if (cap_go) begin
            frm_ff <= last_ff ? '0 : frm_in;
         end
         if (cap_go && last_ff) begin
            snap_vld_ff <= 1'b1;
         end else if (out_free) begin
            snap_vld_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= snap_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_frame_byte;
         last_ff <= req_last_byte;
      end
      if (cap_go && last_ff) begin
         snap_ff      <= frm_in;
         snap_mode_ff <= mode_ff;
      end
   end

   // ---------------- judge ----------------
   logic [4:0]                 status;
   logic                       v6, proto_chk;
   logic [ethp_pkg::IDX_W-1:0] ip_rem;
   logic [15:0]                iplen_cut, v6_tl, tlen;
   logic [5:0]                 hdr, thdr;

   always_comb begin
      status    = ethp_pkg::ST_TCP_OK;
      v6        = 1'b0;
      proto_chk = 1'b0;
      tlen      = '0;
      ip_rem    = snap_ff.idx - 15'(snap_ff.ns);
      hdr       = {snap_ff.hw, 2'b00};
      thdr      = {snap_ff.ofw[15:12], 2'b00};
      iplen_cut = (16'(ip_rem) > snap_ff.iplen) ? snap_ff.iplen : 16'(ip_rem);
      v6_tl     = 16'(ip_rem) - 16'd40;
      if (snap_ff.idx > MAX_IDX) begin
         status = ethp_pkg::ST_TOO_LONG;
      end else if (!snap_mode_ff && snap_ff.idx < 15'd14) begin
         status = ethp_pkg::ST_ETH_SHORT;
      end else if (!snap_mode_ff && snap_ff.ns == ethp_pkg::VLAN_HDR_LEN &&
                   snap_ff.idx < 15'd18) begin
         status = ethp_pkg::ST_BAD_KIND;
      end else if (!snap_mode_ff && snap_ff.ek != ethp_pkg::KIND_IPV4 &&
                   snap_ff.ek != ethp_pkg::KIND_IPV6) begin
         status = ethp_pkg::ST_BAD_KIND;
      end else if (snap_mode_ff && snap_ff.ipver != 4'd4 && snap_ff.ipver != 4'd6) begin
         status = ethp_pkg::ST_RAW_VER;
      end else begin
         v6 = snap_mode_ff ? (snap_ff.ipver == 4'd6) : (snap_ff.ek == ethp_pkg::KIND_IPV6);
         if (!v6) begin
            if (ip_rem < 15'd20)
               status = ethp_pkg::ST_V4_SHORT;
            else if (snap_ff.ipver != 4'd4)
               status = ethp_pkg::ST_V4_VER;
            else if (snap_ff.hw < 4'd5)
               status = ethp_pkg::ST_V4_IHL;
            else if (16'(hdr) > iplen_cut)
               status = ethp_pkg::ST_V4_HDR_LEN;
            else if (snap_ff.frag[13:0] != '0)
               status = ethp_pkg::ST_V4_FRAG;
            else begin
               tlen      = iplen_cut - 16'(hdr);
               proto_chk = 1'b1;
            end
         end else begin
            tlen = (snap_ff.iplen < v6_tl) ? snap_ff.iplen : v6_tl;
            if (ip_rem < 15'd40)
               status = ethp_pkg::ST_V6_SHORT;
            else if (snap_ff.ipver != 4'd6)
               status = ethp_pkg::ST_V6_VER;
            else
               proto_chk = 1'b1;
         end
         if (proto_chk) begin
            if (snap_ff.proto == ethp_pkg::PROTO_UDP)
               status = ethp_pkg::ST_UDP;
            else if (snap_ff.proto != ethp_pkg::PROTO_TCP)
               status = ethp_pkg::ST_BAD_PROTO;
            else if (tlen < 16'd20)
               status = ethp_pkg::ST_TCP_SHORT;
            else if (thdr < 6'd20 || 16'(thdr) > tlen)
               status = ethp_pkg::ST_TCP_OFFSET;
         end
      end
   end

   logic ok;
   assign ok = (status == ethp_pkg::ST_TCP_OK);

   always_ff @(posedge clock) begin
      if (out_free && snap_vld_ff) begin
         rsp_status         <= status;
         rsp_ip_is_v6       <= ok && v6;
         rsp_src_addr_hi    <= (ok && v6) ? snap_ff.src0 : 64'd0;
         rsp_dst_addr_hi    <= (ok && v6) ? snap_ff.dst0 : 64'd0;
         rsp_src_addr_lo    <= !ok ? 64'd0 :
                               v6 ? snap_ff.src1 : {32'h0000FFFF, snap_ff.src1[31:0]};
         rsp_dst_addr_lo    <= !ok ? 64'd0 :
                               v6 ? snap_ff.dst1 : {32'h0000FFFF, snap_ff.dst1[31:0]};
         rsp_src_port       <= ok ? snap_ff.sport : 16'd0;
         rsp_dst_port       <= ok ? snap_ff.dport : 16'd0;
         rsp_seq_num        <= ok ? snap_ff.seq : 32'd0;
         rsp_tcp_flag_bits  <= ok ? snap_ff.ofw[7:0] : 8'd0;
         rsp_payload_offset <= ok ? (15'(snap_ff.ts) + 15'(thdr)) : 15'd0;
         rsp_payload_length <= ok ? 15'(tlen - 16'(thdr)) : 15'd0;
      end
   end

   // ---------------- checks ----------------
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      frm_ff.idx <= MAX_IDX + 15'd1)
      else $error("byte counter past saturation");

   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      snap_vld_ff && !out_free |=> snap_vld_ff)
      else $error("snapshot lost while result stalled");

   a_last_needs_room: assert property (@(posedge clock) disable iff (reset)
      cap_go && last_ff |-> snap_free)
      else $error("snapshot overwritten");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status != ethp_pkg::ST_TCP_OK |->
      rsp_src_port == 16'd0 && rsp_seq_num == 32'd0 && !rsp_ip_is_v6)
      else $error("fields set on non-TCP result");

endmodule
